FILE: hw/rtl/rrss_pkg.sv
`default_nettype none
package rrss_pkg;

  localparam int NUM_CPUS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_THREADS_DEF = 64;

  localparam int TID_W     = 6;
  localparam int TIME_W    = 32;
  localparam int SLICE_W   = 16;
  localparam int CPUS_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;
  localparam logic [CPUS_W-1:0]  CPUS_RESET  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS_IN_USE = 1'b1;

  localparam logic CMD_ACTIVATE = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  localparam logic [1:0] TS_ACTIVE    = 2'd0;
  localparam logic [1:0] TS_FINISHING = 2'd1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BACKWARDS = 2'd2;

  typedef logic [TID_W-1:0]  tid_t;
  typedef logic [TIME_W-1:0] tick_t;

  typedef struct packed {
    logic       command;
    logic [1:0] cpu;
    tid_t       thread_id;
    logic       current_is_idle;
    logic [1:0] thread_state;
    tick_t      now;
  } rrss_in_t;

  typedef struct packed {
    logic       do_switch;
    tid_t       next_thread;
    logic       next_is_idle;
    logic       prev_requeued;
    logic       prev_finished;
    logic [1:0] status;
  } rrss_out_t;

  typedef struct packed {
    logic probe;
    logic push;
  } rrss_qop_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rrss_qstat_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } rrss_sop_t;

endpackage
`default_nettype wire

FILE: hw/rtl/round_robin_slice_scheduler.sv
// Activate: the item is taken, appended to its processor queue, then the result is registered.
// Schedule: the stamp read, time difference and preemption check come first; the scan
// probes one processor queue per cycle, then a still-active preempted thread is requeued.
// One item is in work at a time; the next item is taken the cycle after a result is
// registered, even while it waits.
// Reset is synchronous, active low; items are then refused until the timestamp table is cleared.
`default_nettype none
module round_robin_slice_scheduler #(
  parameter int NUM_CPUS    = rrss_pkg::NUM_CPUS_DEF,
  parameter int QUEUE_DEPTH = rrss_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_THREADS = rrss_pkg::MAX_THREADS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rrss_pkg::rrss_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rrss_pkg::rrss_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [rrss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrss_pkg::SLICE_W-1:0]      cfg_wdata
);
  import rrss_pkg::*;

  localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PUSH   = 4'd2;
  localparam logic [3:0] S_DIFF   = 4'd3;
  localparam logic [3:0] S_EVAL   = 4'd4;
  localparam logic [3:0] S_PROBE  = 4'd5;
  localparam logic [3:0] S_POPGET = 4'd6;
  localparam logic [3:0] S_TAIL   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]        state_r,     state_nxt;
  rrss_in_t          item_r,      item_nxt;
  logic [TIME_W:0]   diff_r,      diff_nxt;
  logic [CPU_W-1:0]  scan_cpu_r,  scan_cpu_nxt;
  logic [CPU_W-1:0]  scan_k_r,    scan_k_nxt;
  rrss_out_t         res_r,       res_nxt;
  rrss_out_t         out_r,       out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLICE_W-1:0] slice_r;
  logic [CPUS_W-1:0]  cpus_r;

  rrss_qop_t         qop;
  rrss_qstat_t       q_stat;
  logic [CPU_W-1:0]  qsel;
  tid_t              q_push_thread;
  tid_t              q_pop_thread;

  rrss_sop_t         sop;
  tid_t              s_wr_tid;
  tick_t             s_rd_time;
  logic              s_busy;

  logic [4:0]        n_use;
  logic [CPU_W-1:0]  cpu_idx;
  logic              eligible;
  logic              preempt;

  rrss_queues #(
    .NUM_CPUS    (NUM_CPUS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (qop),
    .sel         (qsel),
    .push_thread (q_push_thread),
    .stat        (q_stat),
    .pop_thread  (q_pop_thread)
  );

  rrss_stamps #(
    .MAX_THREADS (MAX_THREADS)
  ) u_stamps (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (sop),
    .rd_tid  (in_data.thread_id),
    .wr_tid  (s_wr_tid),
    .wr_time (item_r.now),
    .rd_time (s_rd_time),
    .busy    (s_busy)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (cpus_r == '0) begin
      n_use = 5'd1;
    end else if (5'(cpus_r) > 5'(NUM_CPUS)) begin
      n_use = 5'(NUM_CPUS);
    end else begin
      n_use = 5'(cpus_r);
    end
    cpu_idx  = CPU_W'(item_r.cpu);
    eligible = (scan_k_r == '0) || (5'(scan_cpu_r) < n_use);
    preempt  = item_r.current_is_idle || (item_r.thread_state != TS_ACTIVE) ||
               (diff_r[TIME_W-1:0] > TIME_W'(slice_r));

    state_nxt     = state_r;
    item_nxt      = item_r;
    diff_nxt      = diff_r;
    scan_cpu_nxt  = scan_cpu_r;
    scan_k_nxt    = scan_k_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    qop           = '0;
    qsel          = cpu_idx;
    q_push_thread = item_r.thread_id;
    sop           = '0;
    s_wr_tid      = q_pop_thread;

    case (state_r)
      S_CLEAR: begin
        if (!s_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          res_nxt        = '0;
          res_nxt.status = STAT_OK;
          if (5'(in_data.cpu) >= 5'(NUM_CPUS)) begin
            state_nxt = S_DONE;
          end else if (in_data.command == CMD_ACTIVATE) begin
            state_nxt = S_PUSH;
          end else begin
            sop.rd    = 1'b1;
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        diff_nxt  = {1'b0, item_r.now} - {1'b0, s_rd_time};
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!item_r.current_is_idle && diff_r[TIME_W]) begin
          res_nxt.status = STAT_BACKWARDS;
          state_nxt      = S_DONE;
        end else if (preempt) begin
          scan_cpu_nxt = cpu_idx;
          scan_k_nxt   = '0;
          state_nxt    = S_PROBE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PROBE: begin
        qsel      = scan_cpu_r;
        qop.probe = eligible;
        if (eligible && !q_stat.empty) begin
          state_nxt = S_POPGET;
        end else if (scan_k_r == CPU_W'(NUM_CPUS - 1)) begin
          if (item_r.thread_state != TS_ACTIVE) begin
            res_nxt.do_switch    = 1'b1;
            res_nxt.next_is_idle = 1'b1;
            state_nxt            = S_TAIL;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          scan_k_nxt   = scan_k_r + 1'b1;
          scan_cpu_nxt = (scan_cpu_r == CPU_W'(NUM_CPUS - 1)) ? '0 : scan_cpu_r + 1'b1;
        end
      end
      S_POPGET: begin
        res_nxt.do_switch   = 1'b1;
        res_nxt.next_thread = q_pop_thread;
        sop.wr              = 1'b1;
        state_nxt           = S_TAIL;
      end
      S_TAIL: begin
        if (item_r.current_is_idle || item_r.thread_state != TS_ACTIVE) begin
          res_nxt.prev_finished = (item_r.thread_state == TS_FINISHING);
          state_nxt             = S_DONE;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        qop.push = 1'b1;
        if (q_stat.full) begin
          res_nxt.status = STAT_FULL;
        end else if (item_r.command == CMD_SCHEDULE) begin
          res_nxt.prev_requeued = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      slice_r     <= SLICE_RESET;
      cpus_r      <= CPUS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLICE_TICKS: slice_r <= cfg_wdata;
          CFG_CPUS_IN_USE: cpus_r  <= cfg_wdata[CPUS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    diff_r     <= diff_nxt;
    scan_cpu_r <= scan_cpu_nxt;
    scan_k_r   <= scan_k_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rrss_queues.sv
`default_nettype none
module rrss_queues #(
  parameter int NUM_CPUS    = rrss_pkg::NUM_CPUS_DEF,
  parameter int QUEUE_DEPTH = rrss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  rrss_pkg::rrss_qop_t                               op,
  input  logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] sel,
  input  rrss_pkg::tid_t                                    push_thread,
  output rrss_pkg::rrss_qstat_t                             stat,
  output rrss_pkg::tid_t                                    pop_thread
);
  import rrss_pkg::*;

  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_CPUS * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  logic [HEAD_W-1:0] head_r  [NUM_CPUS];
  logic [CNT_W-1:0]  count_r [NUM_CPUS];
  tid_t              queue_mem [ENTRIES];
  tid_t              pop_r;

  logic [HEAD_W-1:0] head_sel;
  logic [CNT_W-1:0]  count_sel;
  logic [CNT_W:0]    tail_sum;
  logic [HEAD_W-1:0] tail_pos;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              do_pop;
  logic              do_push;

  always_comb begin
    head_sel   = head_r[sel];
    count_sel  = count_r[sel];
    stat.empty = (count_sel == '0);
    stat.full  = (count_sel == CNT_W'(QUEUE_DEPTH));
    do_pop     = op.probe && !stat.empty;
    do_push    = op.push && !stat.full;
    tail_sum   = (CNT_W + 1)'(head_sel) + (CNT_W + 1)'(count_sel);
    if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      tail_pos = HEAD_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH));
    end else begin
      tail_pos = HEAD_W'(tail_sum);
    end
    base    = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH);
    rd_addr = base + ADDR_W'(head_sel);
    wr_addr = base + ADDR_W'(tail_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (do_pop) begin
      head_r[sel]  <= (head_sel == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
      count_r[sel] <= count_sel - 1'b1;
    end else if (do_push) begin
      count_r[sel] <= count_sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue_mem[wr_addr] <= push_thread;
    end
    if (do_pop) begin
      pop_r <= queue_mem[rd_addr];
    end
  end

  assign pop_thread = pop_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rrss_stamps.sv
`default_nettype none
module rrss_stamps #(
  parameter int MAX_THREADS = rrss_pkg::MAX_THREADS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrss_pkg::rrss_sop_t op,
  input  rrss_pkg::tid_t      rd_tid,
  input  rrss_pkg::tid_t      wr_tid,
  input  rrss_pkg::tick_t     wr_time,
  output rrss_pkg::tick_t     rd_time,
  output logic                busy
);
  import rrss_pkg::*;

  localparam int IDX_W = $clog2(MAX_THREADS);

  tick_t             stamp_mem [MAX_THREADS];
  tick_t             rd_r;
  logic [IDX_W-1:0]  clr_r;
  logic              busy_r;

  function automatic logic [IDX_W-1:0] slot(input tid_t t);
    int               m;
    logic [IDX_W-1:0] r;
    m = 0;
    r = '0;
    for (int i = 0; i < (1 << TID_W); i++) begin
      if (TID_W'(i) == t) begin
        r = IDX_W'(m);
      end
      m = (m == MAX_THREADS - 1) ? 0 : m + 1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      if (clr_r == IDX_W'(MAX_THREADS - 1)) begin
        busy_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      stamp_mem[clr_r] <= '0;
    end else if (op.wr) begin
      stamp_mem[slot(wr_tid)] <= wr_time;
    end
    if (op.rd) begin
      rd_r <= stamp_mem[slot(rd_tid)];
    end
  end

  assign rd_time = rd_r;
  assign busy    = busy_r;

endmodule
`default_nettype wire
